### design/pcm_pkg.sv
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int PALETTE_ENTRIES_DEFAULT = 16;

  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;
  localparam int CHAN_W  = 8;
  localparam int LIGHT_W = 11;
  localparam int AXIS_W  = 13;
  localparam int DIFF_W  = AXIS_W + 1;
  localparam int MAG_W   = AXIS_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = SQ_W + 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                     valid;
    logic                     kind;
    logic [INDEX_W-1:0]       entry_index;
    logic [CHAN_W-1:0]        red;
    logic [CHAN_W-1:0]        green;
    logic [CHAN_W-1:0]        blue;
    logic [LIGHT_W-1:0]       lightness;
    logic signed [AXIS_W-1:0] a_axis;
    logic signed [AXIS_W-1:0] b_axis;
    logic                     searched;
    logic [DIST_W-1:0]        best_dist;
    logic [INDEX_W-1:0]       nearest_index;
    logic                     exact_found;
    logic [INDEX_W-1:0]       exact_index;
  } token_t;

endpackage

### design/pcm_intf.sv
`timescale 1ns / 1ps

interface pcm_item_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     kind;
  logic [pcm_pkg::INDEX_W-1:0]              entry_index;
  logic [pcm_pkg::CHAN_W-1:0]               red;
  logic [pcm_pkg::CHAN_W-1:0]               green;
  logic [pcm_pkg::CHAN_W-1:0]               blue;
  logic [pcm_pkg::LIGHT_W-1:0]              lightness;
  logic signed [pcm_pkg::AXIS_W-1:0]        a_axis;
  logic signed [pcm_pkg::AXIS_W-1:0]        b_axis;

  modport source (output valid, kind, entry_index, red, green, blue, lightness, a_axis,
                  b_axis, input ready);
  modport sink   (input valid, kind, entry_index, red, green, blue, lightness, a_axis,
                  b_axis, output ready);
endinterface

interface pcm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        any_entries;
  logic [pcm_pkg::INDEX_W-1:0] nearest_index;
  logic                        exact_found;
  logic [pcm_pkg::INDEX_W-1:0] exact_index;

  modport source (output valid, any_entries, nearest_index, exact_found, exact_index,
                  input ready);
  modport sink   (input valid, any_entries, nearest_index, exact_found, exact_index,
                  output ready);
endinterface

interface pcm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pcm_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### design/pcm_cell.sv
`timescale 1ns / 1ps

module pcm_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [pcm_pkg::COUNT_W-1:0] colors_in_use,
  input  pcm_pkg::token_t             tok_in,
  output pcm_pkg::token_t             tok_out
);

  // palette entry, no reset: undefined until loaded
  logic [pcm_pkg::CHAN_W-1:0]        ent_red;
  logic [pcm_pkg::CHAN_W-1:0]        ent_green;
  logic [pcm_pkg::CHAN_W-1:0]        ent_blue;
  logic [pcm_pkg::LIGHT_W-1:0]       ent_light;
  logic signed [pcm_pkg::AXIS_W-1:0] ent_a;
  logic signed [pcm_pkg::AXIS_W-1:0] ent_b;

  logic                              load_hit;
  logic                              active;
  logic                              rgb_hit;
  logic signed [pcm_pkg::DIFF_W-1:0] d_l, d_a, d_b;
  logic [pcm_pkg::MAG_W-1:0]         m_l, m_a, m_b;

  pcm_pkg::token_t                   s1_tok;
  logic                              s1_active;
  logic                              s1_hit;
  logic [pcm_pkg::SQ_W-1:0]          sq_l, sq_a, sq_b;

  logic [pcm_pkg::DIST_W-1:0]        sum_sq;
  pcm_pkg::token_t                   tok_next;

  assign load_hit = tok_in.valid && tok_in.kind == pcm_pkg::KIND_LOAD &&
                    32'(tok_in.entry_index) == CELL_ID;
  assign active   = 32'(colors_in_use) > CELL_ID;
  assign rgb_hit  = tok_in.red == ent_red && tok_in.green == ent_green &&
                    tok_in.blue == ent_blue;

  assign d_l = pcm_pkg::DIFF_W'(tok_in.lightness) - pcm_pkg::DIFF_W'(ent_light);
  assign d_a = pcm_pkg::DIFF_W'(tok_in.a_axis) - pcm_pkg::DIFF_W'(ent_a);
  assign d_b = pcm_pkg::DIFF_W'(tok_in.b_axis) - pcm_pkg::DIFF_W'(ent_b);
  assign m_l = pcm_pkg::MAG_W'(d_l[pcm_pkg::DIFF_W-1] ? -d_l : d_l);
  assign m_a = pcm_pkg::MAG_W'(d_a[pcm_pkg::DIFF_W-1] ? -d_a : d_a);
  assign m_b = pcm_pkg::MAG_W'(d_b[pcm_pkg::DIFF_W-1] ? -d_b : d_b);

  always_ff @(posedge clk) begin
    if (advance && load_hit) begin
      ent_red   <= tok_in.red;
      ent_green <= tok_in.green;
      ent_blue  <= tok_in.blue;
      ent_light <= tok_in.lightness;
      ent_a     <= tok_in.a_axis;
      ent_b     <= tok_in.b_axis;
    end
  end

  // stage 1: squared differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tok.valid <= 1'b0;
    end else if (advance) begin
      s1_tok    <= tok_in;
      s1_active <= active;
      s1_hit    <= rgb_hit;
      sq_l      <= pcm_pkg::SQ_W'(m_l * m_l);
      sq_a      <= pcm_pkg::SQ_W'(m_a * m_a);
      sq_b      <= pcm_pkg::SQ_W'(m_b * m_b);
    end
  end

  // stage 2: sum, running minimum and first exact match
  assign sum_sq = pcm_pkg::DIST_W'(sq_l) + pcm_pkg::DIST_W'(sq_a) + pcm_pkg::DIST_W'(sq_b);

  always_comb begin
    tok_next = s1_tok;
    if (s1_active && s1_tok.kind == pcm_pkg::KIND_QUERY) begin
      if (!s1_tok.searched || sum_sq < s1_tok.best_dist) begin
        tok_next.best_dist     = sum_sq;
        tok_next.nearest_index = pcm_pkg::INDEX_W'(CELL_ID);
      end
      tok_next.searched = 1'b1;
      if (s1_hit && !s1_tok.exact_found) begin
        tok_next.exact_found = 1'b1;
        tok_next.exact_index = pcm_pkg::INDEX_W'(CELL_ID);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

### design/palette_nearest_color_match.sv
`timescale 1ns / 1ps
// Nearest palette colour matcher.
// item channel: one transaction per load (kind 0, writes entry entry_index
//   with RGB and fixed-point LAB) or per query (kind 1).
// result channel: one transaction per query: first exact RGB match and first
//   entry with the smallest squared LAB distance over entries 0..colors_in_use-1.
// cfg channel: writes colors_in_use; always ready; write only while idle.
// Structure: a chain of PALETTE_ENTRIES cells, each holding one entry and
//   two register stages (squares, then sum and minimum). Every transaction
//   walks the chain; a load writes its entry when it reaches that cell.
// Result: every query passes both register stages of every cell before result valid.
// Throughput: one item per cycle through the two-stage cell chain, unless stalled.
// Stall: a result held by a low result.ready freezes the whole chain and
//   drops item.ready until it is taken; nothing is lost or repeated.
// Reset: chain emptied, colors_in_use cleared to 0. Palette entries are not
//   reset and must be loaded before they are searched.
module palette_nearest_color_match #(
  parameter int PALETTE_ENTRIES = pcm_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  pcm_item_if.sink      item,
  pcm_result_if.source  result,
  pcm_cfg_if.sink       cfg
);

  logic [pcm_pkg::COUNT_W-1:0] colors_in_use;
  logic                        advance;
  pcm_pkg::token_t             head;
  pcm_pkg::token_t             chain [0:PALETTE_ENTRIES];
  pcm_pkg::token_t             last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_in_use <= '0;
    end else if (cfg.valid) begin
      colors_in_use <= cfg.data;
    end
  end

  assign last    = chain[PALETTE_ENTRIES];
  assign advance = !result.valid || result.ready;
  assign item.ready = advance;

  always_comb begin
    head               = '0;
    head.valid         = item.valid;
    head.kind          = item.kind;
    head.entry_index   = item.entry_index;
    head.red           = item.red;
    head.green         = item.green;
    head.blue          = item.blue;
    head.lightness     = item.lightness;
    head.a_axis        = item.a_axis;
    head.b_axis        = item.b_axis;
  end

  assign chain[0] = head;

  for (genvar c = 0; c < PALETTE_ENTRIES; c++) begin : g_cell
    pcm_cell #(
      .CELL_ID (c)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .advance       (advance),
      .colors_in_use (colors_in_use),
      .tok_in        (chain[c]),
      .tok_out       (chain[c+1])
    );
  end

  assign result.valid         = last.valid && last.kind == pcm_pkg::KIND_QUERY;
  assign result.any_entries   = last.searched;
  assign result.nearest_index = last.nearest_index;
  assign result.exact_found   = last.exact_found;
  assign result.exact_index   = last.exact_index;

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.any_entries |->
      result.nearest_index == '0 && !result.exact_found && result.exact_index == '0)
    else $error("empty search gave non-zero result");

  a_any_matches_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.any_entries == (colors_in_use != '0))
    else $error("any_entries disagrees with colors_in_use");

  a_exact_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.exact_found |->
      32'(result.exact_index) < 32'(colors_in_use) &&
      32'(result.exact_index) < PALETTE_ENTRIES)
    else $error("exact match outside searched entries");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !item.ready)
    else $error("item accepted while result stalled");

endmodule
